// ===== hw/rtl/c8ex_pkg.sv =====
`default_nettype none
package c8ex_pkg;
    localparam int MemoryBytes  = 4096;
    localparam int ScreenHeight = 32;
    localparam int StackDepth   = 16;
    localparam logic [15:0] FontBase = 16'd80;

    localparam logic [1:0] MODE_EXEC  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // opcode groups, top nibble of an instruction
    localparam logic [3:0] OPG_SYS  = 4'h0;
    localparam logic [3:0] OPG_JP   = 4'h1;
    localparam logic [3:0] OPG_CALL = 4'h2;
    localparam logic [3:0] OPG_SE   = 4'h3;
    localparam logic [3:0] OPG_SNE  = 4'h4;
    localparam logic [3:0] OPG_SER  = 4'h5;
    localparam logic [3:0] OPG_LD   = 4'h6;
    localparam logic [3:0] OPG_ADD  = 4'h7;
    localparam logic [3:0] OPG_ALU  = 4'h8;
    localparam logic [3:0] OPG_SNER = 4'h9;
    localparam logic [3:0] OPG_LDI  = 4'hA;
    localparam logic [3:0] OPG_JPV  = 4'hB;
    localparam logic [3:0] OPG_RND  = 4'hC;
    localparam logic [3:0] OPG_DRW  = 4'hD;
    localparam logic [3:0] OPG_KEY  = 4'hE;
    localparam logic [3:0] OPG_MISC = 4'hF;

    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [15:0] INS_RET = 16'h00EE;

    localparam logic [7:0] EX_SKP  = 8'h9E;
    localparam logic [7:0] EX_SKNP = 8'hA1;

    localparam logic [7:0] FX_GET_DT   = 8'h07;
    localparam logic [7:0] FX_WAIT_KEY = 8'h0A;
    localparam logic [7:0] FX_SET_DT   = 8'h15;
    localparam logic [7:0] FX_SET_ST   = 8'h18;
    localparam logic [7:0] FX_ADD_I    = 8'h1E;
    localparam logic [7:0] FX_FONT     = 8'h29;
    localparam logic [7:0] FX_BCD      = 8'h33;
    localparam logic [7:0] FX_STORE    = 8'h55;
    localparam logic [7:0] FX_LOAD     = 8'h65;

    // ALU operations of the shared unit
    typedef enum logic [3:0] {
        ALU_MOV  = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } t_alu_op;

    typedef struct packed {
        logic [7:0] res;
        logic [7:0] flag;
    } t_alu_out;
endpackage
`default_nettype wire

// ===== hw/rtl/chip8_instruction_execute_unit_top.sv =====
`default_nettype none
// CHIP-8 instruction execute unit.
// Input stream s_axis: one transaction per command (execute, write memory
// byte, read screen row). Output stream m_axis: one result transaction per
// command: PC, screen row, VF, key wait, screen changed, sound timer.
// Commands are processed one at a time by a sequencer around one ALU, one
// memory port and one screen row port. 00E0 clears one row per cycle;
// Dxyn reads, checks and writes one sprite row at a time; Fx33 writes the
// hundreds, tens and ones digits; Fx55 and Fx65 move V0..Vx one register
// at a time; Fx0A scans one key per cycle.
// s_axis_tready is high only in the idle state; a new command is taken
// once the previous result is handed to the output register.
// When m_axis_tready is low the result is held; the next command may run.
// Reset: V0..VF, I, timers, SP and screen cleared, PC = 0x200. Screen is
// cleared row by row after reset, during which no command enters.
// Memory and call stack are undefined until written.
module chip8_instruction_execute_unit_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // mode[1:0], instruction[17:2], keys[33:18], random_byte[41:34],
    // address[53:42], write_data[61:54], zero[63:62]
    input  wire logic [63:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // program_counter_out[11:0], read_data[75:12], flag_value[83:76],
    // waiting_key[84], screen_changed[85], sound_level[93:86], zero[95:94]
    output logic [95:0]       m_axis_tdata
);
    import c8ex_pkg::*;

    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_DEC  = 10'b0000000100,
        S_CLS  = 10'b0000001000,
        S_DRW  = 10'b0000010000,
        S_BCD  = 10'b0000100000,
        S_STR  = 10'b0001000000,
        S_LDR  = 10'b0010000000,
        S_KEY  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [1:0]  r_mode;
    logic [15:0] r_op, r_keys;
    logic [7:0]  r_rnd, r_wdata;
    logic [11:0] r_addr;
    logic [7:0]  r_v [16];
    logic [15:0] r_i;
    logic [11:0] r_pc;
    logic [3:0]  r_sp;
    logic [7:0]  r_dt, r_st;
    logic [11:0] r_stack [StackDepth];
    logic [7:0]  r_mem [MemoryBytes];
    logic [63:0] r_scr [ScreenHeight];
    logic [4:0]  r_cnt;
    logic [1:0]  r_ph;
    logic [7:0]  r_md, r_bcd, r_dig;
    logic [63:0] r_row, r_rdata;
    logic        r_wait, r_chg;
    logic [5:0]  r_xs;
    logic [4:0]  r_ys;
    logic        r_ovalid;
    logic [95:0] r_odata;

    logic [3:0] w_x, w_y, w_n;
    logic [7:0] w_kk, w_vx, w_vy;
    logic [11:0] w_nnn;
    t_alu_out w_alu;
    logic [5:0] w_row;
    logic [63:0] w_mask;
    logic [11:0] w_ma;
    logic [11:0] w_pc2;
    logic        w_key_down;
    logic [11:0] n_pc;
    t_state      n_state;

    assign w_x = r_op[11:8];
    assign w_y = r_op[7:4];
    assign w_n = r_op[3:0];
    assign w_kk = r_op[7:0];
    assign w_nnn = r_op[11:0];
    assign w_vx = r_v[w_x];
    assign w_vy = r_v[w_y];
    assign w_row = {1'b0, r_ys} + {2'b0, r_cnt[3:0]};
    assign w_mask = {r_md, 56'd0} >> r_xs;
    assign w_ma = r_i[11:0] + {8'd0, r_cnt[3:0]};
    assign w_pc2 = r_pc + 12'd2;
    assign w_key_down = (w_vx < 8'd16) && r_keys[w_vx[3:0]];

    c8ex_alu u_alu (.i_op(w_n), .i_a(w_vx), .i_b(w_vy), .o_out(w_alu));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    // next PC and next state out of decode
    always_comb begin
        n_pc = w_pc2;
        n_state = S_OUT;
        if (r_mode == MODE_EXEC) begin
            unique case (r_op[15:12])
                OPG_SYS: begin
                    if (r_op == INS_CLS) n_state = S_CLS;
                    else if (r_op == INS_RET) n_pc = r_stack[r_sp - 4'd1];
                end
                OPG_JP: n_pc = w_nnn;
                OPG_CALL: n_pc = w_nnn;
                OPG_SE: if (w_vx == w_kk) n_pc = r_pc + 12'd4;
                OPG_SNE: if (w_vx != w_kk) n_pc = r_pc + 12'd4;
                OPG_SER: if (w_vx == w_vy) n_pc = r_pc + 12'd4;
                OPG_SNER: if (w_vx != w_vy) n_pc = r_pc + 12'd4;
                OPG_JPV: n_pc = {4'd0, r_v[0]} + w_nnn;
                OPG_DRW: if (w_n != 4'd0) n_state = S_DRW;
                OPG_KEY: begin
                    if (w_kk == EX_SKP && w_key_down) n_pc = r_pc + 12'd4;
                    else if (w_kk == EX_SKNP && !w_key_down) n_pc = r_pc + 12'd4;
                end
                OPG_MISC: begin
                    unique case (w_kk)
                        FX_WAIT_KEY: n_state = S_KEY;
                        FX_BCD: n_state = S_BCD;
                        FX_STORE: n_state = S_STR;
                        FX_LOAD: n_state = S_LDR;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // memory port and screen row read
    always_ff @(posedge i_clk) begin
        r_md <= r_mem[w_ma];
        r_row <= r_scr[w_row[4:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
            r_i <= '0;
            r_pc <= 12'h200;
            r_sp <= '0;
            r_dt <= '0;
            r_st <= '0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_scr[r_cnt] <= '0;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid) begin
                    r_mode <= s_axis_tdata[1:0];
                    r_op <= s_axis_tdata[17:2];
                    r_keys <= s_axis_tdata[33:18];
                    r_rnd <= s_axis_tdata[41:34];
                    r_addr <= s_axis_tdata[53:42];
                    r_wdata <= s_axis_tdata[61:54];
                    r_wait <= 1'b0;
                    r_chg <= 1'b0;
                    r_rdata <= '0;
                    r_cnt <= '0;
                    r_ph <= '0;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= n_state;
                    if (r_mode == MODE_WRITE) begin
                        r_mem[r_addr] <= r_wdata;
                    end else if (r_mode == MODE_READ) begin
                        if (r_addr < 12'd32) r_rdata <= r_scr[r_addr[4:0]];
                    end else if (r_mode == MODE_EXEC) begin
                        r_pc <= n_pc;
                        unique case (r_op[15:12])
                            OPG_SYS: if (r_op == INS_RET) r_sp <= r_sp - 4'd1;
                            OPG_CALL: begin
                                r_stack[r_sp] <= w_pc2;
                                r_sp <= r_sp + 4'd1;
                            end
                            OPG_LD: r_v[w_x] <= w_kk;
                            OPG_ADD: r_v[w_x] <= w_vx + w_kk;
                            OPG_ALU: begin
                                case (w_n) inside
                                    ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: begin
                                        if (w_x != 4'hF) r_v[15] <= w_alu.flag;
                                        r_v[w_x] <= w_alu.res;
                                    end
                                    ALU_MOV, ALU_OR, ALU_AND, ALU_XOR: r_v[w_x] <= w_alu.res;
                                    default: ;
                                endcase
                            end
                            OPG_LDI: r_i <= {4'd0, w_nnn};
                            OPG_RND: r_v[w_x] <= r_rnd & w_kk;
                            OPG_DRW: begin
                                r_xs <= w_vx[5:0];
                                r_ys <= w_vy[4:0];
                                r_v[15] <= '0;
                            end
                            OPG_MISC: begin
                                unique case (w_kk)
                                    FX_GET_DT: r_v[w_x] <= r_dt;
                                    FX_SET_DT: r_dt <= w_vx;
                                    FX_SET_ST: r_st <= w_vx;
                                    FX_ADD_I: r_i <= r_i + {8'd0, w_vx};
                                    FX_FONT: r_i <= FontBase + {6'd0, w_vx, 2'd0}
                                                + {8'd0, w_vx};
                                    FX_BCD: begin
                                        r_bcd <= w_vx;
                                        r_dig <= '0;
                                    end
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLS: begin
                    if (r_scr[r_cnt] != '0) r_chg <= 1'b1;
                    r_scr[r_cnt] <= '0;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= S_OUT;
                end
                S_DRW: begin
                    // phase 0 address, 1 data ready, 2 write row
                    if (w_row[5]) r_state <= S_OUT;
                    else if (r_ph != 2'd2) r_ph <= r_ph + 2'd1;
                    else begin
                        if ((r_row & w_mask) != '0) r_v[15] <= 8'd1;
                        if (w_mask != '0) r_chg <= 1'b1;
                        r_scr[w_row[4:0]] <= r_row ^ w_mask;
                        r_ph <= '0;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt[3:0] + 4'd1 == w_n) r_state <= S_OUT;
                    end
                end
                S_BCD: begin
                    // r_dig counts hundreds, then tens, by repeated subtraction
                    if (r_ph == 2'd0) begin
                        if (r_bcd >= 8'd100) begin
                            r_bcd <= r_bcd - 8'd100;
                            r_dig <= r_dig + 8'd1;
                        end else begin
                            r_mem[r_i[11:0]] <= r_dig;
                            r_dig <= '0;
                            r_ph <= 2'd1;
                        end
                    end else if (r_ph == 2'd1) begin
                        if (r_bcd >= 8'd10) begin
                            r_bcd <= r_bcd - 8'd10;
                            r_dig <= r_dig + 8'd1;
                        end else begin
                            r_mem[r_i[11:0] + 12'd1] <= r_dig;
                            r_ph <= 2'd2;
                        end
                    end else begin
                        r_mem[r_i[11:0] + 12'd2] <= r_bcd;
                        r_state <= S_OUT;
                    end
                end
                S_STR: begin
                    r_mem[w_ma] <= r_v[r_cnt[3:0]];
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt[3:0] == w_x) r_state <= S_OUT;
                end
                S_LDR: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else begin
                        r_v[r_cnt[3:0]] <= r_md;
                        r_ph <= '0;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt[3:0] == w_x) r_state <= S_OUT;
                    end
                end
                S_KEY: begin
                    if (r_keys[r_cnt[3:0]]) begin
                        r_v[w_x] <= {4'd0, r_cnt[3:0]};
                        r_state <= S_OUT;
                    end else if (r_cnt[3:0] == 4'hF) begin
                        r_pc <= r_pc - 12'd2;
                        r_wait <= 1'b1;
                        r_state <= S_OUT;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_OUT: if (!r_ovalid || m_axis_tready) begin
                    r_ovalid <= 1'b1;
                    r_odata <= {2'b0, r_st, r_chg, r_wait, r_v[15], r_rdata, r_pc};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/c8ex_alu.sv =====
`default_nettype none
module c8ex_alu (
    input  wire logic [3:0]          i_op,
    input  wire logic [7:0]          i_a,
    input  wire logic [7:0]          i_b,
    output c8ex_pkg::t_alu_out       o_out
);
    import c8ex_pkg::*;
    logic [8:0] w_sum;
    always_comb begin
        w_sum = {1'b0, i_a} + {1'b0, i_b};
        o_out = '{res: i_a, flag: 8'd0};
        case (i_op)
            ALU_MOV: o_out.res = i_b;
            ALU_OR:  o_out.res = i_a | i_b;
            ALU_AND: o_out.res = i_a & i_b;
            ALU_XOR: o_out.res = i_a ^ i_b;
            ALU_ADD: o_out = '{res: w_sum[7:0], flag: {7'd0, w_sum[8]}};
            ALU_SUB: o_out = '{res: i_a - i_b, flag: {7'd0, i_a > i_b}};
            ALU_SHR: o_out = '{res: {1'b0, i_a[7:1]}, flag: {7'd0, i_a[0]}};
            ALU_SUBN: o_out = '{res: i_b - i_a, flag: {7'd0, i_b > i_a}};
            ALU_SHL: o_out = '{res: {i_a[6:0], 1'b0}, flag: {7'd0, i_a[7]}};
            default: o_out = '{res: i_a, flag: 8'd0};
        endcase
    end
endmodule
`default_nettype wire
